/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the settled reading detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property on i_clk, ignored while reset is asserted.
`define SRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked property on i_clk, also evaluated during reset.
`define SRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

/* rtl/srd_pkg.sv */
// Package with types and constants of the settled reading detector.
`timescale 1ns / 1ps

package srd_pkg;

    // Ring depth and field widths.
    localparam int RING_SIZE  = 5;
    localparam int SAMPLE_W   = 10;
    localparam int CFG_W      = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int IDX_W      = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int SUM_W      = SAMPLE_W + IDX_W;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = STATUS_W + SAMPLE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Division of the ring sum by RING_SIZE through a rounded-up reciprocal.
    // The shift is wide enough that the quotient is exact for every sum.
    localparam int RECIP_SHIFT = SUM_W + IDX_W;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + RING_SIZE - 1) / RING_SIZE;
    localparam int PROD_W      = SUM_W + RECIP_SHIFT;

    // Register reset values.
    localparam logic [CFG_W-1:0] TOLERANCE_RESET = CFG_W'(3);
    localparam logic [CFG_W-1:0] AGREEMENT_RESET = CFG_W'(4);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AGREEMENT = CFG_IDX_W'(1);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_REF_TAKEN  = 3'd0,
        ST_IDLE       = 3'd1,
        ST_COLLECTING = 3'd2,
        ST_ABORTED    = 3'd3,
        ST_SETTLED    = 3'd4
    } t_status;

    typedef logic [SAMPLE_W-1:0] t_sample;

endpackage

/* rtl/settled_reading_detector_core.sv */
// Top level of the settled reading detector: reference, capture ring and settle check.
//
// Channel     Direction  Handshake                       Content
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready  one converter sample
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready  status and average
// cfg         in         i_cfg_valid/o_cfg_ready          register index and value
//
// One sample is accepted per cycle unless the output stalls; a sample passes the input
// register, then the result register. The ring check (near tests, pairwise spread, sum
// and reciprocal divide) is the one logic stage between those two registers.
// Reset (synchronous, active low) clears the reference, the capture state and the ring.
// A stalled result transaction is held, and the input stalls only while both registers
// are full and the result is not taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module settled_reading_detector_core
    import srd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Sample stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [9:0] sample
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [2:0] status, [12:3] average
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SIZE - 1);

    // Configuration registers.
    logic [CFG_W-1:0] r_tolerance;
    logic [CFG_W-1:0] r_agreement;

    // Input register.
    logic    r_s1_valid;
    t_sample r_sample;

    // Detector state.
    t_sample          r_reference;
    logic             r_ref_valid;
    logic             r_capturing;
    logic [IDX_W-1:0] r_write_index;
    t_sample          r_ring [RING_SIZE];

    // Next state.
    t_sample          n_reference;
    logic             n_ref_valid;
    logic             n_capturing;
    logic [IDX_W-1:0] n_write_index;
    logic             n_ring_write;
    t_status          n_status;

    // Result register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SAMPLE_W-1:0] r_out_average;

    // Stage logic.
    logic                out_free;
    logic                s1_move;
    logic                s_accept;
    logic                near_sample;
    logic [IDX_W-1:0]    cap_idx;
    logic [IDX_W-1:0]    step_idx;
    t_sample             w_ring [RING_SIZE];
    logic [RING_SIZE-1:0] entry_far;
    logic                spread_ok;
    logic                ring_ok;
    logic [SUM_W-1:0]    ring_sum;
    logic [PROD_W-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] ring_avg;

    // Strictly inside (reference - tolerance, reference + tolerance), without wrap.
    function automatic logic is_near(input t_sample x, input t_sample r,
                                     input logic [CFG_W-1:0] t);
        logic [SAMPLE_W:0] x_plus_t;
        logic [SAMPLE_W:0] r_plus_t;
        x_plus_t = {1'b0, x} + {1'b0, t};
        r_plus_t = {1'b0, r} + {1'b0, t};
        return (x_plus_t > {1'b0, r}) && ({1'b0, x} < r_plus_t);
    endfunction

    // Handshake flow through the two registers.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOLERANCE_RESET;
            r_agreement <= AGREEMENT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                CFG_AGREEMENT: r_agreement <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // Slot that this sample lands in, and the index after it.
    assign near_sample = is_near(r_sample, r_reference, r_tolerance);
    assign cap_idx     = r_capturing ? r_write_index : '0;
    assign step_idx    = (cap_idx == LAST_IDX) ? '0 : cap_idx + 1'b1;

    // Ring as it stands once this sample is written.
    always_comb begin
        for (int i = 0; i < RING_SIZE; i++) begin
            w_ring[i] = (cap_idx == IDX_W'(i)) ? r_sample : r_ring[i];
        end
    end

    // Every entry far from the reference, and no pair further apart than the bound.
    always_comb begin
        logic [SAMPLE_W:0] hi_limit;
        spread_ok = 1'b1;
        for (int i = 0; i < RING_SIZE; i++) begin
            entry_far[i] = !is_near(w_ring[i], r_reference, r_tolerance);
            for (int k = 0; k < RING_SIZE; k++) begin
                hi_limit = {1'b0, w_ring[k]} + {1'b0, r_agreement};
                if ({1'b0, w_ring[i]} > hi_limit) begin
                    spread_ok = 1'b0;
                end
            end
        end
    end

    assign ring_ok = (&entry_far) && spread_ok;

    // Truncated mean of the ring.
    always_comb begin
        ring_sum = '0;
        for (int i = 0; i < RING_SIZE; i++) begin
            ring_sum = ring_sum + SUM_W'(w_ring[i]);
        end
    end

    assign avg_prod = PROD_W'(ring_sum) * PROD_W'(RECIP);
    assign ring_avg = SAMPLE_W'(avg_prod >> RECIP_SHIFT);

    // Next state and status for the sample in the input register.
    always_comb begin
        n_reference   = r_reference;
        n_ref_valid   = r_ref_valid;
        n_capturing   = r_capturing;
        n_write_index = r_write_index;
        n_ring_write  = 1'b0;
        n_status      = ST_IDLE;
        if (!r_ref_valid) begin
            n_reference = r_sample;
            n_ref_valid = 1'b1;
            n_status    = ST_REF_TAKEN;
        end else if (near_sample) begin
            if (r_capturing) begin
                n_capturing = 1'b0;
                n_status    = ST_ABORTED;
            end
        end else begin
            n_ring_write  = 1'b1;
            n_write_index = step_idx;
            n_capturing   = 1'b1;
            n_status      = ST_COLLECTING;
            if (step_idx == LAST_IDX && ring_ok) begin
                n_capturing = 1'b0;
                n_status    = ST_SETTLED;
            end
        end
    end

    // Detector state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference   <= '0;
            r_ref_valid   <= 1'b0;
            r_capturing   <= 1'b0;
            r_write_index <= '0;
            for (int i = 0; i < RING_SIZE; i++) begin
                r_ring[i] <= '0;
            end
        end else if (s1_move) begin
            r_reference   <= n_reference;
            r_ref_valid   <= n_ref_valid;
            r_capturing   <= n_capturing;
            r_write_index <= n_write_index;
            if (n_ring_write) begin
                for (int i = 0; i < RING_SIZE; i++) begin
                    r_ring[i] <= w_ring[i];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status  <= n_status;
            r_out_average <= (n_status == ST_SETTLED) ? ring_avg : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), r_out_average, r_out_status};

    // A capture can only run once a reference exists.
    `SRD_ASSERT(a_capture_needs_ref, r_capturing |-> r_ref_valid, "capture without reference")
    // The write index never leaves the ring.
    `SRD_ASSERT(a_index_in_ring, r_write_index <= LAST_IDX, "write index beyond ring")
    // Both registers full and the output stalled: no new sample may enter.
    `SRD_ASSERT(a_full_stalls_input,
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready,
        "input accepted while pipeline full")
    // The first processed sample becomes the reference.
    `SRD_ASSERT(a_first_sets_ref,
        (i_rst_n && s1_move && !r_ref_valid) |=>
            (r_ref_valid && r_reference == $past(r_sample)),
        "reference not taken from first sample")
    // A settled result closes the capture.
    `SRD_ASSERT(a_settle_ends_capture,
        (i_rst_n && s1_move && n_status == ST_SETTLED) |=> !r_capturing,
        "capture still open after settle")

endmodule
